// ===== design/lrs_pkg.sv =====
// Package for the line raster stepper: coordinate width, command codes,
// octant flags and the packed payload types of both channels.
// No dependencies.
`timescale 1ns / 1ps

package lrs_pkg;

  // Width of one screen coordinate.
  localparam int COORD_BITS = 12;

  // Command codes carried in the cmd field.
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // Octant flags: bit 0 swaps x and y, bit 1 negates x, bit 2 negates y.
  typedef struct packed {
    logic negy;
    logic negx;
    logic swap;
  } lrs_oct_t;

  // One input transfer.
  typedef struct packed {
    logic                  cmd;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
  } lrs_in_t;

  // One result transfer.
  typedef struct packed {
    logic                  pixel_valid;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;
  } lrs_out_t;

endpackage

// ===== design/line_raster_stepper_top.sv =====
// Line raster stepper: sets up a line in any octant by mirroring it into the first
// octant, emits its start pixel and steps one pixel per advance command. Depends on lrs_pkg.
`timescale 1ns / 1ps

//  channel | ports                         | direction
//  --------+-------------------------------+----------
//  input   | in_valid, in_stall, in_data   | in
//  result  | out_valid, out_stall, out_data| out
//
// Every accepted command yields one result in the next cycle; one command can
// be accepted in every cycle unless a held result stalls, set by the single
// add-and-compare error step. Reset (rst_n low, synchronous) drops any active
// line and empties the result register. The input is stalled only while a
// result is held and the result side stalls.
module line_raster_stepper_top import lrs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  lrs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output lrs_out_t out_data
);

  localparam int C = COORD_BITS;

  // Unit step of a mirrored coordinate.
  localparam logic signed [C:0] STEP_ONE = {{C{1'b0}}, 1'b1};

  // Line state.
  logic                  line_active_r, line_active_nxt;
  logic signed [C:0]     mirrored_x_r, mirrored_x_nxt;
  logic signed [C:0]     mirrored_y_r, mirrored_y_nxt;
  logic signed [C:0]     mirrored_end_x_r, mirrored_end_x_nxt;
  logic signed [C+2:0]   error_term_r, error_term_nxt;
  logic        [C:0]     twice_dx_r, twice_dx_nxt;
  logic        [C:0]     twice_dy_r, twice_dy_nxt;
  lrs_oct_t              octant_r, octant_nxt;

  // Result register.
  logic                  out_valid_r;
  lrs_out_t              out_data_r, out_data_nxt;

  logic                  in_acc;

  // Setup terms for a start command.
  logic signed [C:0]     sx, sy, ex, ey;
  logic signed [C:0]     dx, dy;
  logic        [C:0]     adx_w, ady_w;
  logic        [C-1:0]   adx, ady, mdx, mdy;
  logic signed [C:0]     nsx, nsy, nex, ney;
  lrs_oct_t              oct_s;

  // Operands of the pixel step, from setup or from the line state.
  logic signed [C:0]     cur_x, cur_y, cur_end;
  logic signed [C+2:0]   cur_err;
  logic        [C:0]     cur_2dx, cur_2dy;
  lrs_oct_t              cur_oct;
  logic signed [C+2:0]   err_add;
  logic                  y_step, is_last;
  logic signed [C:0]     u, v;

  // A transfer is taken unless a held result is stalled.
  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Octant detection and mirroring of both endpoints.
  always_comb begin
    sx = $signed({1'b0, in_data.start_x});
    sy = $signed({1'b0, in_data.start_y});
    ex = $signed({1'b0, in_data.end_x});
    ey = $signed({1'b0, in_data.end_y});
    dx = ex - sx;
    dy = ey - sy;
    adx_w = (dx < 0) ? $unsigned(-dx) : $unsigned(dx);
    ady_w = (dy < 0) ? $unsigned(-dy) : $unsigned(dy);
    adx = adx_w[C-1:0];
    ady = ady_w[C-1:0];
    oct_s.negx = (dx < 0);
    oct_s.negy = (dy < 0);
    oct_s.swap = (ady > adx);
    nsx = oct_s.negx ? -sx : sx;
    nsy = oct_s.negy ? -sy : sy;
    nex = oct_s.negx ? -ex : ex;
    ney = oct_s.negy ? -ey : ey;
    mdx = oct_s.swap ? ady : adx;
    mdy = oct_s.swap ? adx : ady;
  end

  // Pixel emission, error update and next state.
  always_comb begin
    if (in_data.cmd == CMD_START) begin
      cur_x   = oct_s.swap ? nsy : nsx;
      cur_y   = oct_s.swap ? nsx : nsy;
      cur_end = oct_s.swap ? ney : nex;
      cur_err = -$signed({3'b000, mdx});
      cur_2dx = {mdx, 1'b0};
      cur_2dy = {mdy, 1'b0};
      cur_oct = oct_s;
    end else begin
      cur_x   = mirrored_x_r;
      cur_y   = mirrored_y_r;
      cur_end = mirrored_end_x_r;
      cur_err = error_term_r;
      cur_2dx = twice_dx_r;
      cur_2dy = twice_dy_r;
      cur_oct = octant_r;
    end

    is_last = (cur_x >= cur_end);
    err_add = cur_err + $signed({2'b00, cur_2dy});
    y_step  = (err_add >= 0);

    // Map the mirrored position back: swap first, then negate.
    u = cur_oct.swap ? cur_y : cur_x;
    v = cur_oct.swap ? cur_x : cur_y;
    if (cur_oct.negx) begin
      u = -u;
    end
    if (cur_oct.negy) begin
      v = -v;
    end

    line_active_nxt    = line_active_r;
    mirrored_x_nxt     = mirrored_x_r;
    mirrored_y_nxt     = mirrored_y_r;
    mirrored_end_x_nxt = mirrored_end_x_r;
    error_term_nxt     = error_term_r;
    twice_dx_nxt       = twice_dx_r;
    twice_dy_nxt       = twice_dy_r;
    octant_nxt         = octant_r;
    out_data_nxt       = '0;

    if (in_data.cmd == CMD_START || line_active_r) begin
      out_data_nxt.pixel_valid = 1'b1;
      out_data_nxt.pixel_x     = u[C-1:0];
      out_data_nxt.pixel_y     = v[C-1:0];
      out_data_nxt.last_pixel  = is_last;
      line_active_nxt    = !is_last;
      mirrored_x_nxt     = cur_x + STEP_ONE;
      mirrored_y_nxt     = y_step ? cur_y + STEP_ONE : cur_y;
      mirrored_end_x_nxt = cur_end;
      error_term_nxt     = y_step ? err_add - $signed({2'b00, cur_2dx}) : err_add;
      twice_dx_nxt       = cur_2dx;
      twice_dy_nxt       = cur_2dy;
      octant_nxt         = cur_oct;
    end
  end

  // State and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_active_r    <= 1'b0;
      mirrored_x_r     <= '0;
      mirrored_y_r     <= '0;
      mirrored_end_x_r <= '0;
      error_term_r     <= '0;
      twice_dx_r       <= '0;
      twice_dy_r       <= '0;
      octant_r         <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (in_acc) begin
        line_active_r    <= line_active_nxt;
        mirrored_x_r     <= mirrored_x_nxt;
        mirrored_y_r     <= mirrored_y_nxt;
        mirrored_end_x_r <= mirrored_end_x_nxt;
        error_term_r     <= error_term_nxt;
        twice_dx_r       <= twice_dx_nxt;
        twice_dy_r       <= twice_dy_nxt;
        octant_r         <= octant_nxt;
        out_valid_r      <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r      <= 1'b0;
      end
    end
  end

  // Result payload loads on every accepted transfer.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef SYNTH
  // An idle result carries no coordinates and no last flag.
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.pixel_valid) |->
      (out_data.pixel_x == '0 && out_data.pixel_y == '0 && !out_data.last_pixel))
    else $error("idle result with nonzero payload");

  // Emitting the end point closes the line.
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && out_data_nxt.last_pixel) |=> !line_active_r)
    else $error("line still active after last pixel");

  // An advance with no active line leaves the position untouched.
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.cmd == CMD_ADVANCE && !line_active_r) |=>
      ($stable(mirrored_x_r) && $stable(mirrored_y_r) && !line_active_r))
    else $error("state moved on idle advance");
`endif

endmodule
